### rtl/core/lbh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line bucket hash package
// Shared constants, register map and the finish request passed from the
// accumulator to the result stage.
// ----------------------------------------------------------------------------
package lbh_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned OUT_W  = 39;

	localparam logic [ADDR_W-1:0] REG_HASH_SIZE_LOG  = 3'd0;
	localparam logic [ADDR_W-1:0] REG_COMPARE_LENGTH = 3'd4;

	localparam logic [5:0]  HASH_SIZE_LOG_RESET = 6'd24;
	localparam logic [63:0] MIX_CONST  = 64'd1812433253;
	localparam logic [63:0] FOLD_BITS  = 64'hF800_0000_0000_0000;
	localparam int unsigned SHIFT_STEP = 5;

	typedef enum logic [1:0] {
		LEN_EMPTY,
		LEN_ONE,
		LEN_MULTI
	} len_class_t;

	typedef struct packed {
		logic        valid;
		len_class_t  len;
		logic [5:0]  lg;
		logic [63:0] hash;
		logic [63:0] extra;
	} fin_req_t;

endpackage

### rtl/core/lbh_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line bucket hash accumulator
// Holds the running hash and extra values and the byte position of the open
// line. The extra update multiplies in two stages: partial products first,
// then the sum and the optional fold.
// ----------------------------------------------------------------------------
module lbh_accum #(
	parameter int unsigned CNT_W = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         line_byte,
	input  logic [5:0]         lg,
	input  logic [CNT_W-1:0]   limit,
	output lbh_pkg::fin_req_t  fin
);

	logic [63:0]      hash_q;
	logic [63:0]      extra_q;
	logic [CNT_W-1:0] pos_q;

	logic             is_zero;
	logic             step;
	logic             odd_mul;
	logic [63:0]      mask;
	logic [63:0]      hash_fold;
	logic             fold;
	logic [63:0]      mul_op;
	logic [63:0]      p_ll_c;
	logic [31:0]      p_lh_c;
	logic [31:0]      p_hl_c;

	logic             mul_valid_s1;
	logic [63:0]      p_ll_s1;
	logic [31:0]      p_lh_s1;
	logic [31:0]      p_hl_s1;
	logic [7:0]       byte_s1;
	logic             fold_s1;

	logic [63:0]      ext_sum;
	logic [63:0]      ext_new;
	logic [63:0]      extra_cur;

	assign is_zero = (line_byte == 8'd0);
	assign step    = take && !is_zero && (pos_q < limit);
	assign odd_mul = step && pos_q[0] && (pos_q != CNT_W'(1));

	assign mask      = ~({64{1'b1}} << lg);
	assign hash_fold = (hash_q ^ (hash_q >> lg)) & mask;
	assign fold      = |(hash_q & lbh_pkg::FOLD_BITS);

	// Only the low 64 bits of the full product are kept, so the high by
	// high term drops out and the cross terms need only their low halves.
	assign mul_op = hash_q | lbh_pkg::MIX_CONST;
	assign p_ll_c = 64'(extra_q[31:0]) * 64'(mul_op[31:0]);
	assign p_lh_c = extra_q[31:0] * mul_op[63:32];
	assign p_hl_c = extra_q[63:32] * mul_op[31:0];

	assign ext_sum = p_ll_s1 + {p_lh_s1 + p_hl_s1, 32'b0} + {56'b0, byte_s1};
	assign ext_new = fold_s1 ? (ext_sum ^ (ext_sum >> lg)) : ext_sum;

	// A product still in flight belongs to the line that is open now.
	assign extra_cur = mul_valid_s1 ? ext_new : extra_q;

	always_comb begin
		fin.valid = take && is_zero;
		fin.lg    = lg;
		fin.hash  = hash_q;
		fin.extra = extra_cur;
		if (pos_q == '0) begin
			fin.len = lbh_pkg::LEN_EMPTY;
		end else if (pos_q == CNT_W'(1)) begin
			fin.len = lbh_pkg::LEN_ONE;
		end else begin
			fin.len = lbh_pkg::LEN_MULTI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q       <= '0;
			extra_q      <= '0;
			pos_q        <= '0;
			mul_valid_s1 <= 1'b0;
		end else begin
			mul_valid_s1 <= odd_mul;
			if (take && is_zero) begin
				hash_q  <= '0;
				extra_q <= '0;
				pos_q   <= '0;
			end else begin
				if (step && (pos_q == CNT_W'(1))) begin
					extra_q <= {56'b0, line_byte};
				end else begin
					extra_q <= extra_cur;
				end
				if (step) begin
					pos_q <= pos_q + CNT_W'(1);
					if (pos_q == '0) begin
						hash_q <= {56'b0, line_byte};
					end else if (!pos_q[0]) begin
						hash_q <= (hash_q << lbh_pkg::SHIFT_STEP) + {56'b0, line_byte};
					end else if (odd_mul && fold) begin
						hash_q <= hash_fold;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (odd_mul) begin
			p_ll_s1 <= p_ll_c;
			p_lh_s1 <= p_lh_c;
			p_hl_s1 <= p_hl_c;
			byte_s1 <= line_byte;
			fold_s1 <= fold;
		end
	end

	// Odd positions are at least two words apart, so products never queue.
	a_mul_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		mul_valid_s1 |=> !mul_valid_s1)
		else $error("two multiply stages in consecutive cycles");

endmodule

### rtl/core/lbh_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line bucket hash finish stage
// Mixes the final hash and extra values of a line into a bucket index and
// queues results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module lbh_finish (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbh_pkg::fin_req_t          req,
	output logic                       space,
	output logic                       bucket_valid,
	input  logic                       bucket_ready,
	output logic [lbh_pkg::OUT_W-1:0]  bucket_index
);

	logic                      fin_valid_q;
	lbh_pkg::len_class_t       len_s1;
	logic [5:0]                lg_s1;
	logic [63:0]               hash_s1;
	logic [63:0]               extra_s1;

	logic [lbh_pkg::OUT_W-1:0] buf_q [2];
	logic                      head_q;
	logic [1:0]                cnt_q;

	logic [5:0]                half;
	logic [63:0]               mask;
	logic [63:0]               mix_a;
	logic [63:0]               mix_b;
	logic [lbh_pkg::OUT_W-1:0] result;
	logic                      push;
	logic                      pop;
	logic                      tail;

	assign half  = lg_s1 >> 1;
	assign mask  = ~({64{1'b1}} << lg_s1);
	assign mix_a = (hash_s1 - extra_s1) ^ (extra_s1 << half);
	assign mix_b = (mix_a ^ (mix_a >> lg_s1)) & mask;

	always_comb begin
		case (len_s1)
			lbh_pkg::LEN_EMPTY: result = '0;
			lbh_pkg::LEN_ONE:   result = hash_s1[lbh_pkg::OUT_W-1:0];
			default:            result = mix_b[lbh_pkg::OUT_W-1:0];
		endcase
	end

	assign push = fin_valid_q && (cnt_q != 2'd2);
	assign pop  = bucket_valid && bucket_ready;
	assign tail = head_q ^ cnt_q[0];

	assign bucket_valid = (cnt_q != 2'd0);
	assign bucket_index = buf_q[head_q];

	// One finished line may wait here besides the two buffered words.
	assign space = ({1'b0, fin_valid_q} + cnt_q) < 2'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_q <= 1'b0;
			head_q      <= 1'b0;
			cnt_q       <= 2'd0;
		end else begin
			fin_valid_q <= req.valid || (fin_valid_q && !push);
			if (pop) begin
				head_q <= !head_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			len_s1   <= req.len;
			lg_s1    <= req.lg;
			hash_s1  <= req.hash;
			extra_s1 <= req.extra;
		end
		if (push) begin
			buf_q[tail] <= result;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid_q && !push) |=> (fin_valid_q && $stable(hash_s1) && $stable(extra_s1)))
		else $error("blocked finish stage lost its line");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_valid_q && !push) |-> !req.valid)
		else $error("new line end while finish stage is blocked");

endmodule

### rtl/core/line_bucket_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line bucket hash
// Hashes a text line, one byte per word, to a bucket index. A zero byte ends
// the line and produces one result word.
//
//   Channel   Signals                                Direction  Word
//   apb       psel penable pwrite paddr pwdata       in         register write
//             prdata pready                          out        read data
//   line      line_valid line_ready line_byte        in         one byte
//   bucket    bucket_valid bucket_ready bucket_index out        39-bit index
//
// One byte is taken every cycle while line_ready is high; the 64-bit multiply
// for odd positions is split over two stages, which the alternation of
// positions hides. A result passes the mix stage register and then the output
// buffer after its terminating zero byte. Two results are buffered and a third
// may wait in the mix stage; only when all three are held does line_ready fall.
// Reset clears the line state and loads the register defaults.
// ----------------------------------------------------------------------------
module line_bucket_hash #(
	parameter int unsigned MAX_LINE = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lbh_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        line_valid,
	output logic                        line_ready,
	input  logic [7:0]                  line_byte,
	output logic                        bucket_valid,
	input  logic                        bucket_ready,
	output logic [lbh_pkg::OUT_W-1:0]   bucket_index
);

	localparam int unsigned POS_W = $clog2(MAX_LINE + 1);
	localparam int unsigned CNT_W = (POS_W > 10) ? POS_W : 10;

	logic [5:0]        hash_size_log_q;
	logic [9:0]        compare_length_q;
	logic              wr_en;
	logic              take;
	logic [CNT_W-1:0]  lim_raw;
	logic [CNT_W-1:0]  limit;
	lbh_pkg::fin_req_t fin;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr)
			lbh_pkg::REG_HASH_SIZE_LOG:  prdata = {26'b0, hash_size_log_q};
			lbh_pkg::REG_COMPARE_LENGTH: prdata = {22'b0, compare_length_q};
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_size_log_q  <= lbh_pkg::HASH_SIZE_LOG_RESET;
			compare_length_q <= '0;
		end else if (wr_en) begin
			unique case (paddr)
				lbh_pkg::REG_HASH_SIZE_LOG:  hash_size_log_q  <= pwdata[5:0];
				lbh_pkg::REG_COMPARE_LENGTH: compare_length_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// A zero length means the full line; the two seed bytes are always taken.
	assign lim_raw = (compare_length_q == '0) ? CNT_W'(MAX_LINE) : CNT_W'(compare_length_q);
	assign limit   = (lim_raw < CNT_W'(2)) ? CNT_W'(2) : lim_raw;

	assign take = line_valid && line_ready;

	lbh_accum #(
		.CNT_W(CNT_W)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.line_byte (line_byte),
		.lg        (hash_size_log_q),
		.limit     (limit),
		.fin       (fin)
	);

	lbh_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (fin),
		.space        (line_ready),
		.bucket_valid (bucket_valid),
		.bucket_ready (bucket_ready),
		.bucket_index (bucket_index)
	);

endmodule
